// ===== rtl/surjection_counter_top_assert.svh =====
// Assertion macros for the surjection counter, empty in synthesis builds.
`ifndef SURJECTION_COUNTER_TOP_ASSERT_SVH
`define SURJECTION_COUNTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define SC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("surjection counter assertion failed");

// Next-cycle implication, checked out of reset.
`define SC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("surjection counter assertion failed");

`else

`define SC_ASSERT_NOW(label, ante, cons)
`define SC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/sc_pkg.sv =====
// Shared widths and limits of the surjection counter.
package sc_pkg;

  // Width of a set size field.
  localparam int SIZE_W = 6;
  // Width of a count value.
  localparam int COUNT_W = 64;
  // Default largest set size handled.
  localparam int SC_MAX_SIZE = 63;

endpackage

// ===== rtl/sc_ifs.sv =====
// Request and response channel interfaces of the surjection counter.
interface sc_req_if;
  logic                       valid;
  logic                       ready;
  logic [sc_pkg::SIZE_W-1:0]  set_size_from;
  logic [sc_pkg::SIZE_W-1:0]  set_size_onto;

  modport source (output valid, output set_size_from, output set_size_onto, input ready);
  modport sink (input valid, input set_size_from, input set_size_onto, output ready);
endinterface

interface sc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [sc_pkg::COUNT_W-1:0] map_count;
  logic                       overflowed;

  modport source (output valid, output map_count, output overflowed, input ready);
  modport sink (input valid, input map_count, input overflowed, output ready);
endinterface

// ===== rtl/surjection_counter_top.sv =====
// Surjection counter top level: row recurrence over a row memory with one read and one write port.
//
// Usage: an item on req carries m (set_size_from) and n (set_size_onto). One
// item on rsp returns the number of onto maps from an m-set to an n-set,
// modulo 2^64, with overflowed set when any recurrence value left 64 bits.
// Sizes above MAX_SIZE give a count of 0 with overflowed set.
// The count follows T(j,k) = k * (T(j-1,k) + T(j-1,k-1)) over the band of
// cells with j - k <= m - n and k <= n, one cell at a time, in place in the
// row memory. Each cell passes through a memory read, an add, and a
// multiply with write back, and each of the m rows first fetches its
// first cell. Trivial cases (m < n, n = 0, size out of range) skip the
// rows and go straight to the result.
// One item is worked on at a time. A finished result sits in the rsp output
// register; the next item is accepted while it waits, and the block stalls
// before delivering that next result until rsp is free.
// Reset is synchronous and clears the control state; the row memory needs no
// clearing, since each cell is written in the item before it is read.
module surjection_counter_top #(
  parameter int MAX_SIZE = sc_pkg::SC_MAX_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  sc_req_if.sink      req,
  sc_rsp_if.source    rsp
);

  `include "surjection_counter_top_assert.svh"

  localparam int DEPTH  = MAX_SIZE + 1;
  localparam int AW     = $clog2(DEPTH);
  localparam int SW     = sc_pkg::SIZE_W;
  localparam int CW     = sc_pkg::COUNT_W;
  localparam int PW     = CW + SW;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROW  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]     state;
  logic [SW-1:0]  m_r;
  logic [SW-1:0]  n_r;
  logic [SW-1:0]  j;
  logic [SW-1:0]  k;
  logic [SW-1:0]  lo;
  logic [CW-1:0]  cur;
  logic [CW-1:0]  sum;
  logic           ovf;
  logic [CW-1:0]  res_count;
  logic           res_ovf;
  logic           rsp_valid;
  logic [CW-1:0]  rsp_count;
  logic           rsp_ovf;

  // Row memory with a registered read port.
  logic [CW-1:0]  row_mem [DEPTH];
  logic [CW-1:0]  rdata;
  logic [AW-1:0]  raddr;
  logic           we;

  logic [SW-1:0]  hi;
  logic [SW-1:0]  diff;
  logic [SW-1:0]  lo_calc;
  logic [CW-1:0]  lower;
  logic [CW:0]    add_full;
  logic [PW-1:0]  prod;
  logic           ovf_next;
  logic           req_fire;
  logic           rsp_free;

  assign req.ready     = (state == ST_IDLE);
  assign req_fire      = req.valid && (state == ST_IDLE);
  assign rsp_free      = !rsp_valid || rsp.ready;
  assign rsp.valid     = rsp_valid;
  assign rsp.map_count = rsp_count;
  assign rsp.overflowed = rsp_ovf;

  // Band limits of row j.
  assign hi      = (j < n_r) ? j : n_r;
  assign diff    = m_r - n_r;
  assign lo_calc = ({1'b0, j} > ({1'b0, diff} + 7'd1)) ? (j - diff) : SW'(1);

  // Cell arithmetic: left neighbor of the old row, add, then multiply by k.
  assign lower    = (k == SW'(1)) ? ((j == SW'(1)) ? CW'(1) : '0) : rdata;
  assign add_full = {1'b0, cur} + {1'b0, lower};
  assign prod     = PW'(k) * PW'(sum);
  assign ovf_next = ovf || (prod[PW-1:CW] != '0);

  // Read address: first cell of a row, then the left neighbor of each cell.
  always_comb begin
    unique case (state)
      ST_ROW:  raddr = AW'(hi);
      ST_LOAD,
      ST_RD:   raddr = AW'(k - SW'(1));
      default: raddr = AW'(k);
    endcase
  end

  assign we = (state == ST_MUL);

  always_ff @(posedge clk) begin
    rdata <= row_mem[raddr];
    if (we) begin
      row_mem[AW'(k)] <= prod[CW-1:0];
    end
  end

  // Sequencer over rows and cells.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      ovf       <= 1'b0;
    end else begin
      // The output register takes a finished result once it is free.
      if (state == ST_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
        rsp_count <= res_count;
        rsp_ovf   <= res_ovf;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            m_r <= req.set_size_from;
            n_r <= req.set_size_onto;
            j   <= SW'(1);
            ovf <= 1'b0;
            priority if (int'(req.set_size_from) > MAX_SIZE ||
                         int'(req.set_size_onto) > MAX_SIZE) begin
              res_count <= '0;
              res_ovf   <= 1'b1;
              state     <= ST_DONE;
            end else if (req.set_size_onto == '0) begin
              res_count <= (req.set_size_from == '0) ? CW'(1) : '0;
              res_ovf   <= 1'b0;
              state     <= ST_DONE;
            end else if (req.set_size_from < req.set_size_onto) begin
              res_count <= '0;
              res_ovf   <= 1'b0;
              state     <= ST_DONE;
            end else begin
              state <= ST_ROW;
            end
          end
        end
        ST_ROW: begin
          k     <= hi;
          lo    <= lo_calc;
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          // The top cell of a growing band has no old value: it is zero.
          cur   <= (k == j) ? '0 : rdata;
          state <= ST_ADD;
        end
        ST_RD: begin
          state <= ST_ADD;
        end
        ST_ADD: begin
          sum   <= add_full[CW-1:0];
          ovf   <= ovf || add_full[CW];
          cur   <= lower;
          state <= ST_MUL;
        end
        ST_MUL: begin
          ovf <= ovf_next;
          if (k == lo) begin
            if (j == m_r) begin
              res_count <= prod[CW-1:0];
              res_ovf   <= ovf_next;
              state     <= ST_DONE;
            end else begin
              j     <= j + SW'(1);
              state <= ST_ROW;
            end
          end else begin
            k     <= k - SW'(1);
            state <= ST_RD;
          end
        end
        ST_DONE: begin
          if (rsp_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The cell being written lies within the band of its row.
  `SC_ASSERT_NOW(a_cell_in_band, state == ST_MUL, k >= lo && k <= n_r && k >= SW'(1))
  // Row index stays between one and m while a row is in progress.
  `SC_ASSERT_NOW(a_row_in_range, state == ST_ROW || state == ST_ADD,
                 j >= SW'(1) && j <= m_r)
  // Entry zero of the row memory is never written.
  `SC_ASSERT_NOW(a_no_write_zero, we, k != '0)
  // A finished result moves to the output register once it is free.
  `SC_ASSERT_NEXT(a_result_out, state == ST_DONE && rsp_free,
                  rsp_valid && state == ST_IDLE)

endmodule
